FILE: design/rcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared types, codes and the sine table of the column renderer.
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int DIST_W = 9;

    typedef enum logic [3:0] {
        F_IDLE, F_ANG, F_SIN, F_COS, F_E2, F_MARCH, F_LEN,
        F_DOT, F_SQ, F_L2, F_PR, F_DL, F_CMP, F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE, B_DIV, B_END, B_ROWS
    } t_bstate;

    localparam logic [3:0] G_BLANK  = 4'd0;
    localparam logic [3:0] G_FULL   = 4'd1;
    localparam logic [3:0] G_DARK   = 4'd2;
    localparam logic [3:0] G_MEDIUM = 4'd3;
    localparam logic [3:0] G_LIGHT  = 4'd4;
    localparam logic [3:0] G_HASH   = 4'd5;
    localparam logic [3:0] G_X      = 4'd6;
    localparam logic [3:0] G_DOT    = 4'd7;
    localparam logic [3:0] G_DASH   = 4'd8;

    localparam logic [2:0] CFG_MAP_A = 3'd0;
    localparam logic [2:0] CFG_MAP_B = 3'd1;
    localparam logic [2:0] CFG_MAP_C = 3'd2;
    localparam logic [2:0] CFG_MAP_D = 3'd3;
    localparam logic [2:0] CFG_DEPTH = 3'd4;

    typedef struct packed {
        logic [255:0] wall_map;
        logic [4:0]   max_depth;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] steps;
        logic [3:0]        shade;
    } t_col;

    localparam logic [14:0] QSINE [33] = '{
        15'd0, 15'd804, 15'd1606, 15'd2404, 15'd3196, 15'd3981, 15'd4756,
        15'd5520, 15'd6270, 15'd7005, 15'd7723, 15'd8423, 15'd9102, 15'd9760,
        15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160,
        15'd13623, 15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426,
        15'd15679, 15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364,
        15'd16384
    };

    // Q1.14 sine, 4096 units per turn, quarter table with linear interpolation
    function automatic logic signed [15:0] sine_q14(input logic [11:0] a);
        logic [10:0] p;
        logic [5:0]  i;
        logic [4:0]  f;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [14:0] df;
        logic [19:0] pr;
        logic [14:0] v;
        p = {1'b0, a[9:0]};
        if (a[10]) p = 11'd1024 - p;
        i = p[10:5];
        f = p[4:0];
        if (i >= 6'd32) begin
            v = 15'd16384;
        end else begin
            lo = QSINE[i[4:0]];
            hi = QSINE[i[4:0] + 6'd1];
            df = hi - lo;
            pr = 20'(df) * 20'(f);
            v  = lo + pr[19:5];
        end
        return a[11] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

FILE: design/rcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_queue
// Small FIFO of cast columns between the ray front end and the row emitter.
// ----------------------------------------------------------------------------
module rcr_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcr_pkg::t_col i_data,
    output logic          o_full,
    input  logic          i_pop,
    output rcr_pkg::t_col o_data,
    output logic          o_empty
);
    import rcr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_col            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [AW:0]     r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count overflow");

endmodule

FILE: design/rcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_front
// Ray front end: ray angle, sine and cosine, march over the wall map,
// corner edge test and shade choice for one column.
// ----------------------------------------------------------------------------
module rcr_front #(
    parameter int SCREEN_COLUMNS = 120,
    parameter int MAP_SIDE       = 16,
    parameter int FOV_UNITS      = 512,
    parameter int STEPS_PER_CELL = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rcr_pkg::t_cfg i_cfg,
    input  logic          i_push,
    output logic          o_full,
    input  logic [11:0]   i_player_x,
    input  logic [11:0]   i_player_y,
    input  logic [11:0]   i_view_angle,
    input  logic [6:0]    i_column,
    output logic          o_q_push,
    output rcr_pkg::t_col o_q_data,
    input  logic          i_q_full
);
    import rcr_pkg::*;

    // column offset col * FOV / SCREEN_COLUMNS by reciprocal multiply
    localparam int     XW  = 7 + $clog2(FOV_UNITS) + 1;
    localparam int     SH  = XW + $clog2(SCREEN_COLUMNS);
    localparam longint RCP = ((longint'(1) << SH) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
    localparam longint FRC = RCP * FOV_UNITS;
    localparam int     PW  = $clog2(FRC + 1) + 7;
    localparam int     K   = STEPS_PER_CELL * 16384;
    localparam int     RW  = $clog2(K) + 2;

    t_fstate                r_state, n_state;
    logic [11:0]            r_px, n_px, r_py, n_py, r_view, n_view, r_ang, n_ang;
    logic [6:0]             r_col, n_col;
    logic signed [15:0]     r_ex, n_ex, r_ey, n_ey;
    logic [29:0]            r_e2, n_e2;
    logic signed [5:0]      r_cx, n_cx, r_cy, n_cy;
    logic signed [RW-1:0]   r_rx, n_rx, r_ry, n_ry;
    logic [DIST_W-1:0]      r_d, n_d, r_dmax, n_dmax, r_dist, n_dist;
    logic                   r_edge, n_edge;
    logic [1:0]             r_k, n_k, r_far, n_far;
    logic [25:0]            r_far_len2, n_far_len2, r_len2, n_len2;
    logic signed [30:0]     r_dot, n_dot;
    logic [55:0]            r_x, n_x, r_p, n_p, r_m, n_m;

    logic [PW-1:0]          ofs_p;
    logic [11:0]            ofs;
    logic [4:0]             dep;
    logic signed [RW-1:0]   sx, sy, mx, my;
    logic signed [5:0]      mcx, mcy;
    logic                   outside, wall;
    logic [4:0]             cxt, cyt;
    logic signed [13:0]     vx, vy;
    logic signed [27:0]     vx2, vy2;
    logic [25:0]            len2;
    logic signed [61:0]     dsq;
    logic signed [56:0]     delta;
    logic [69:0]            tm;
    logic [3:0]             shade;
    logic [10:0]            dl, dm;

    assign o_full = (r_state != F_IDLE);

    always_comb begin
        ofs_p = PW'(r_col) * PW'(FRC);
        ofs   = 12'(ofs_p >> SH);
        dep  = (i_cfg.max_depth == 5'd0) ? 5'd1 :
               (i_cfg.max_depth > 5'd16) ? 5'd16 : i_cfg.max_depth;

        sx  = r_rx + RW'(r_ex);
        sy  = r_ry + RW'(r_ey);
        mx  = sx;
        mcx = r_cx;
        if (sx >= RW'(K)) begin
            mx = sx - RW'(K); mcx = r_cx + 6'sd1;
        end else if (sx < 0) begin
            mx = sx + RW'(K); mcx = r_cx - 6'sd1;
        end
        my  = sy;
        mcy = r_cy;
        if (sy >= RW'(K)) begin
            my = sy - RW'(K); mcy = r_cy + 6'sd1;
        end else if (sy < 0) begin
            my = sy + RW'(K); mcy = r_cy - 6'sd1;
        end
        outside = (mcx < 0) || (mcx >= 6'(MAP_SIDE)) || (mcy < 0) || (mcy >= 6'(MAP_SIDE));
        wall    = i_cfg.wall_map[{mcy[3:0], mcx[3:0]}];

        cxt  = {1'b0, r_cx[3:0]} + {4'b0, r_k[1]};
        cyt  = {1'b0, r_cy[3:0]} + {4'b0, r_k[0]};
        vx   = $signed({1'b0, cxt, 8'b0}) - $signed({2'b0, r_px});
        vy   = $signed({1'b0, cyt, 8'b0}) - $signed({2'b0, r_py});
        vx2  = vx * vx;
        vy2  = vy * vy;
        len2 = 26'(vx2) + 26'(vy2);

        dsq   = r_dot * r_dot;
        delta = $signed({1'b0, r_x}) - $signed({1'b0, r_p});
        tm    = ({14'b0, r_m} << 13) + ({14'b0, r_m} << 10) + ({14'b0, r_m} << 9)
              + ({14'b0, r_m} << 8) + ({14'b0, r_m} << 4);

        dl = {r_dist, 2'b0};
        dm = 11'(r_dist) * 11'd3;
        if (dl <= 11'(r_dmax))                  shade = G_FULL;
        else if (dm < 11'(r_dmax))              shade = G_DARK;
        else if ({1'b0, r_dist, 1'b0} < 11'(r_dmax)) shade = G_MEDIUM;
        else if (r_dist < r_dmax)               shade = G_LIGHT;
        else                                    shade = G_BLANK;
        if (r_edge) shade = G_BLANK;
    end

    always_comb begin
        n_state = r_state; n_px = r_px; n_py = r_py; n_view = r_view; n_ang = r_ang;
        n_col = r_col; n_ex = r_ex; n_ey = r_ey; n_e2 = r_e2;
        n_cx = r_cx; n_cy = r_cy; n_rx = r_rx; n_ry = r_ry; n_d = r_d;
        n_dmax = r_dmax; n_dist = r_dist; n_edge = r_edge; n_k = r_k; n_far = r_far;
        n_far_len2 = r_far_len2; n_len2 = r_len2; n_dot = r_dot; n_x = r_x;
        n_p = r_p; n_m = r_m;
        o_q_push = 1'b0;
        o_q_data.steps = r_dist;
        o_q_data.shade = shade;
        case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_px   = i_player_x;
                    n_py   = i_player_y;
                    n_view = i_view_angle;
                    n_col  = i_column;
                    n_dmax = DIST_W'(dep) * DIST_W'(STEPS_PER_CELL);
                    n_edge = 1'b0;
                    n_state = F_ANG;
                end
            end
            F_ANG: begin
                n_ang   = r_view - 12'(FOV_UNITS / 2) + ofs;
                n_state = F_SIN;
            end
            F_SIN: begin
                n_ex    = sine_q14(r_ang);
                n_state = F_COS;
            end
            F_COS: begin
                n_ey    = sine_q14(r_ang + 12'd1024);
                n_state = F_E2;
            end
            F_E2: begin
                n_e2 = 30'(32'(r_ex * r_ex) + 32'(r_ey * r_ey));
                n_cx = $signed({2'b0, r_px[11:8]});
                n_cy = $signed({2'b0, r_py[11:8]});
                n_rx = $signed(RW'(r_px[7:0]) * RW'(64 * STEPS_PER_CELL));
                n_ry = $signed(RW'(r_py[7:0]) * RW'(64 * STEPS_PER_CELL));
                n_d  = DIST_W'(1);
                n_state = F_MARCH;
            end
            F_MARCH: begin
                n_rx = mx; n_ry = my; n_cx = mcx; n_cy = mcy;
                if (outside) begin
                    n_dist  = r_dmax;
                    n_state = F_PUSH;
                end else if (wall) begin
                    n_dist  = r_d;
                    n_k     = 2'd0;
                    n_state = F_LEN;
                end else if (r_d == r_dmax) begin
                    n_dist  = r_dmax;
                    n_state = F_PUSH;
                end else begin
                    n_d = r_d + 1'b1;
                end
            end
            F_LEN: begin
                if (r_k == 2'd0 || len2 >= r_far_len2) begin
                    n_far      = r_k;
                    n_far_len2 = len2;
                end
                n_k = r_k + 1'b1;
                if (r_k == 2'd3) n_state = F_DOT;
            end
            F_DOT: begin
                if (r_k == r_far) begin
                    if (r_k == 2'd3) n_state = F_PUSH;
                    else n_k = r_k + 1'b1;
                end else begin
                    n_dot   = 31'(r_ex * vx) + 31'(r_ey * vy);
                    n_state = F_SQ;
                end
            end
            F_SQ: begin
                if (r_dot <= 0) begin
                    if (r_k == 2'd3) n_state = F_PUSH;
                    else begin n_k = r_k + 1'b1; n_state = F_DOT; end
                end else begin
                    n_x     = dsq[55:0] - 56'd1;
                    n_state = F_L2;
                end
            end
            F_L2: begin
                n_len2  = len2;
                n_state = F_PR;
            end
            F_PR: begin
                n_p     = 56'(r_e2) * 56'(r_len2);
                n_state = F_DL;
            end
            F_DL: begin
                if (!delta[56]) begin
                    n_edge  = 1'b1;
                    n_state = F_PUSH;
                end else begin
                    n_m     = r_p - r_x;
                    n_state = F_CMP;
                end
            end
            F_CMP: begin
                if ({14'b0, r_p} >= tm) begin
                    n_edge  = 1'b1;
                    n_state = F_PUSH;
                end else if (r_k == 2'd3) begin
                    n_state = F_PUSH;
                end else begin
                    n_k = r_k + 1'b1; n_state = F_DOT;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px; r_py <= n_py; r_view <= n_view; r_ang <= n_ang;
        r_col <= n_col; r_ex <= n_ex; r_ey <= n_ey;
        r_e2 <= n_e2; r_cx <= n_cx; r_cy <= n_cy; r_rx <= n_rx; r_ry <= n_ry;
        r_d <= n_d; r_dmax <= n_dmax; r_dist <= n_dist; r_edge <= n_edge;
        r_k <= n_k; r_far <= n_far; r_far_len2 <= n_far_len2; r_len2 <= n_len2;
        r_dot <= n_dot; r_x <= n_x; r_p <= n_p; r_m <= n_m;
    end

    a_march_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_MARCH) |-> (r_d <= r_dmax && r_d != '0))
        else $error("march step beyond depth limit");

    a_edge_hit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && r_edge) |-> (r_dist <= r_dmax))
        else $error("edge flag without wall hit");

endmodule

FILE: design/rcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_back
// Row emitter: ceiling row by serial division, then one glyph per row.
// ----------------------------------------------------------------------------
module rcr_back #(
    parameter int SCREEN_ROWS    = 40,
    parameter int STEPS_PER_CELL = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rcr_pkg::t_col i_q_data,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic [5:0]    o_row,
    output logic [3:0]    o_glyph,
    output logic [7:0]    o_distance_steps,
    output logic          o_last_row,
    output logic          o_empty,
    input  logic          i_pop
);
    import rcr_pkg::*;

    localparam int NW = $clog2(SCREEN_ROWS * 16 * STEPS_PER_CELL + 1);
    localparam int DW = $clog2(32 * STEPS_PER_CELL + 1);
    localparam int IW = $clog2(NW + 1);
    localparam int CW = NW + 2;

    t_bstate               r_state, n_state;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic [3:0]            r_shade, n_shade;
    logic                  r_neg, n_neg;
    logic [NW-1:0]         r_q, n_q;
    logic [DW-1:0]         r_rm, n_rm, r_den, n_den;
    logic [IW-1:0]         r_i, n_i;
    logic signed [CW-1:0]  r_ceil, n_ceil;
    logic [5:0]            r_y, n_y;
    logic                  r_out_valid, n_out_valid;
    logic [5:0]            r_out_row, n_out_row;
    logic [3:0]            r_out_glyph, n_out_glyph;
    logic [7:0]            r_out_dist, n_out_dist;
    logic                  r_out_last, n_out_last;

    logic signed [CW-1:0]  num;
    logic [DW:0]           dt;
    logic signed [CW-1:0]  ys, fl;
    logic [11:0]           rr;
    logic [3:0]            g;
    logic                  slot;

    assign o_row            = r_out_row;
    assign o_glyph          = r_out_glyph;
    assign o_distance_steps = r_out_dist;
    assign o_last_row       = r_out_last;
    assign o_empty          = !r_out_valid;

    always_comb begin
        num  = $signed(CW'(SCREEN_ROWS) * CW'(i_q_data.steps)
             - CW'(2 * SCREEN_ROWS * STEPS_PER_CELL));
        dt   = {r_rm, r_q[NW-1]};
        ys   = $signed(CW'(r_y));
        fl   = CW'(SCREEN_ROWS) - r_ceil;
        rr   = 12'(SCREEN_ROWS) - 12'(r_y);
        if (ys < r_ceil)                          g = G_BLANK;
        else if (ys > r_ceil && ys <= fl)         g = r_shade;
        else if ((rr << 3) < 12'(SCREEN_ROWS))    g = G_HASH;
        else if ((rr << 2) < 12'(SCREEN_ROWS))    g = G_X;
        else if ((rr << 3) < 12'(3 * SCREEN_ROWS)) g = G_DOT;
        else if (rr * 12'd20 < 12'(9 * SCREEN_ROWS)) g = G_DASH;
        else                                      g = G_BLANK;
        slot = !r_out_valid || i_pop;
    end

    always_comb begin
        n_state = r_state; n_dist = r_dist; n_shade = r_shade; n_neg = r_neg;
        n_q = r_q; n_rm = r_rm; n_den = r_den; n_i = r_i; n_ceil = r_ceil; n_y = r_y;
        n_out_valid = r_out_valid && !i_pop;
        n_out_row = r_out_row; n_out_glyph = r_out_glyph;
        n_out_dist = r_out_dist; n_out_last = r_out_last;
        o_q_pop = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_dist  = i_q_data.steps;
                    n_shade = i_q_data.shade;
                    n_neg   = num[CW-1];
                    n_q     = num[CW-1] ? NW'(-num) : NW'(num);
                    n_rm    = '0;
                    n_den   = DW'({i_q_data.steps, 1'b0});
                    n_i     = '0;
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                n_i = r_i + 1'b1;
                if (dt >= {1'b0, r_den}) begin
                    n_rm = DW'(dt - {1'b0, r_den});
                    n_q  = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_rm = DW'(dt);
                    n_q  = {r_q[NW-2:0], 1'b0};
                end
                if (r_i == IW'(NW - 1)) n_state = B_END;
            end
            B_END: begin
                n_ceil  = r_neg ? -$signed(CW'(r_q)) : $signed(CW'(r_q));
                n_y     = '0;
                n_state = B_ROWS;
            end
            B_ROWS: begin
                if (slot) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_y;
                    n_out_glyph = g;
                    n_out_dist  = r_dist[7:0];
                    n_out_last  = (r_y == 6'(SCREEN_ROWS - 1));
                    if (r_y == 6'(SCREEN_ROWS - 1)) n_state = B_IDLE;
                    else n_y = r_y + 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist; r_shade <= n_shade; r_neg <= n_neg; r_q <= n_q;
        r_rm <= n_rm; r_den <= n_den; r_i <= n_i; r_ceil <= n_ceil; r_y <= n_y;
        r_out_row <= n_out_row; r_out_glyph <= n_out_glyph;
        r_out_dist <= n_out_dist; r_out_last <= n_out_last;
    end

    a_row_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_pop && !r_out_last) |=>
        (r_out_valid && r_out_row == $past(r_out_row) + 6'd1))
        else $error("next row not ready after beat");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_row == 6'(SCREEN_ROWS - 1))))
        else $error("last row flag mismatch");

endmodule

FILE: design/raycast_column_renderer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_renderer_core
// Grid ray caster: one input beat casts one screen column, the result side
// delivers one glyph beat per screen row.
// ----------------------------------------------------------------------------
// channel   handshake        payload
// input     i_push / o_full  i_player_x, i_player_y, i_view_angle, i_column
// result    o_empty / i_pop  o_row, o_glyph, o_distance_steps, o_last_row
// config    i_cfg_we         i_cfg_idx, i_cfg_data
//
// Front end per column: the angle, sine and cosine, a march of up to
// 16*STEPS_PER_CELL steps, then on a hit four corner lengths and edge tests.
// Back end: serial division, then one row per cycle while beats are taken,
// overlapped with the next column's march through a two-entry column queue.
// o_full is high from accept until the column enters the queue; a full queue
// or a held result beat stalls the stage behind it.
// Synchronous active-low reset; map resets to empty, depth limit to 16.
// ----------------------------------------------------------------------------
module raycast_column_renderer_core #(
    parameter int SCREEN_ROWS    = 40,
    parameter int SCREEN_COLUMNS = 120,
    parameter int MAP_SIDE       = 16,
    parameter int FOV_UNITS      = 512,
    parameter int STEPS_PER_CELL = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [11:0] i_player_x,
    input  logic [11:0] i_player_y,
    input  logic [11:0] i_view_angle,
    input  logic [6:0]  i_column,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [5:0]  o_row,
    output logic [3:0]  o_glyph,
    output logic [7:0]  o_distance_steps,
    output logic        o_last_row
);
    import rcr_pkg::*;

    logic [63:0] r_map_a, r_map_b, r_map_c, r_map_d;
    logic [4:0]  r_depth;
    t_cfg        cfg;
    logic        q_push, q_full, q_pop, q_empty;
    t_col        q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_a <= '0;
            r_map_b <= '0;
            r_map_c <= '0;
            r_map_d <= '0;
            r_depth <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_A: r_map_a <= i_cfg_data;
                CFG_MAP_B: r_map_b <= i_cfg_data;
                CFG_MAP_C: r_map_c <= i_cfg_data;
                CFG_MAP_D: r_map_d <= i_cfg_data;
                CFG_DEPTH: r_depth <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign cfg.wall_map  = {r_map_d, r_map_c, r_map_b, r_map_a};
    assign cfg.max_depth = r_depth;

    rcr_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .MAP_SIDE       (MAP_SIDE),
        .FOV_UNITS      (FOV_UNITS),
        .STEPS_PER_CELL (STEPS_PER_CELL)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_player_x   (i_player_x),
        .i_player_y   (i_player_y),
        .i_view_angle (i_view_angle),
        .i_column     (i_column),
        .o_q_push     (q_push),
        .o_q_data     (q_in),
        .i_q_full     (q_full)
    );

    rcr_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    rcr_back #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .STEPS_PER_CELL (STEPS_PER_CELL)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_data         (q_out),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .o_row            (o_row),
        .o_glyph          (o_glyph),
        .o_distance_steps (o_distance_steps),
        .o_last_row       (o_last_row),
        .o_empty          (o_empty),
        .i_pop            (i_pop)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the column renderer: columns are cast under several wall maps and
// depth limits, every row beat is compared against a cycle-free prediction
// of the ray march, edge test and glyph shading.
// ----------------------------------------------------------------------------
module tb;
    import rcr_pkg::*;

    localparam int ROWS  = 40;
    localparam int STEPS = 10;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic [5:0] row;
        logic [3:0] glyph;
        logic [7:0] steps;
        logic       last;
    } t_glyph_beat;

    class column_board;
        t_glyph_beat  glyphs_due[$];
        logic [255:0] walls;
        logic [4:0]   depth;
        int           mismatches;

        function new();
            walls = '0;
            depth = 5'd16;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                CFG_MAP_A: walls[63:0]    = data;
                CFG_MAP_B: walls[127:64]  = data;
                CFG_MAP_C: walls[191:128] = data;
                CFG_MAP_D: walls[255:192] = data;
                CFG_DEPTH: depth = data[4:0];
                default: ;
            endcase
        endfunction

        function int sin_q14(int unsigned a);
            int unsigned p;
            int unsigned i;
            int unsigned f;
            int          v;
            a = a & 4095;
            p = a & 1023;
            if (a & 1024) p = 1024 - p;
            i = p >> 5;
            f = p & 31;
            if (i >= 32) v = 16384;
            else v = QSINE[i] + (((int'(QSINE[i + 1]) - int'(QSINE[i])) * f) >> 5);
            return (a & 2048) ? -v : v;
        endfunction

        function longint cell_idx(longint pos);
            if (pos < 0) return -1;
            return pos / (STEPS * 16384);
        endfunction

        function void note_column(int px, int py, int unsigned va, int unsigned col);
            int unsigned       dep;
            int unsigned       ang;
            longint            lim, hit_d, cx, cy, ceil_row, floor_row, num, r;
            longint            ex, ey, dot;
            longint            vx[4], vy[4];
            longint unsigned   len2[4], e2, pw, dot2;
            bit                hit, edge_col;
            int                far_k, g, shade;
            t_glyph_beat       b;
            dep = depth;
            if (dep == 0) dep = 1;
            if (dep > 16) dep = 16;
            lim = dep * STEPS;
            ang = (va + 4096 - 256 + (col * 512) / 120) & 4095;
            ex = sin_q14(ang);
            ey = sin_q14(ang + 1024);
            hit_d = lim;
            hit = 0;
            edge_col = 0;
            cx = 0;
            cy = 0;
            for (longint d = 1; d <= lim; d++) begin
                cx = cell_idx(px * 640 + ex * d);
                cy = cell_idx(py * 640 + ey * d);
                if (cx < 0 || cx >= 16 || cy < 0 || cy >= 16) break;
                if (walls[cy * 16 + cx]) begin
                    hit = 1;
                    hit_d = d;
                    break;
                end
            end
            if (hit) begin
                e2 = ex * ex + ey * ey;
                far_k = 0;
                for (int k = 0; k < 4; k++) begin
                    vx[k] = ((cx + (k >> 1)) << 8) - px;
                    vy[k] = ((cy + (k & 1)) << 8) - py;
                    len2[k] = vx[k] * vx[k] + vy[k] * vy[k];
                    if (len2[k] >= len2[far_k]) far_k = k;
                end
                for (int k = 0; k < 4; k++) begin
                    if (k != far_k) begin
                        dot = ex * vx[k] + ey * vy[k];
                        if (dot > 0) begin
                            pw = e2 * len2[k];
                            dot2 = longint'(dot) * longint'(dot);
                            if (dot2 > pw - pw / 10000) edge_col = 1;
                        end
                    end
                end
            end
            if (hit_d * 4 <= lim) shade = G_FULL;
            else if (hit_d * 3 < lim) shade = G_DARK;
            else if (hit_d * 2 < lim) shade = G_MEDIUM;
            else if (hit_d < lim) shade = G_LIGHT;
            else shade = G_BLANK;
            if (edge_col) shade = G_BLANK;
            num = ROWS * hit_d - 2 * ROWS * STEPS;
            ceil_row = num / (2 * hit_d);
            floor_row = ROWS - ceil_row;
            for (int y = 0; y < ROWS; y++) begin
                r = ROWS - y;
                if (y < ceil_row) g = G_BLANK;
                else if (y > ceil_row && y <= floor_row) g = shade;
                else if (8 * r < ROWS) g = G_HASH;
                else if (4 * r < ROWS) g = G_X;
                else if (8 * r < 3 * ROWS) g = G_DOT;
                else if (20 * r < 9 * ROWS) g = G_DASH;
                else g = G_BLANK;
                b.row = 6'(y);
                b.glyph = 4'(g);
                b.steps = hit_d[7:0];
                b.last = (y == ROWS - 1);
                glyphs_due = {glyphs_due, b};
            end
        endfunction

        function void check(t_glyph_beat got);
            t_glyph_beat want;
            if (glyphs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat row %0d", got.row);
                return;
            end
            want = glyphs_due.pop_front();
            if (got.row !== want.row || got.glyph !== want.glyph ||
                got.steps !== want.steps || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp row %0d glyph %0d dist %0d last %0d, got %0d %0d %0d %0d",
                             want.row, want.glyph, want.steps, want.last,
                             got.row, got.glyph, got.steps, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_push = 0;
    logic        o_full;
    logic [11:0] i_player_x = '0;
    logic [11:0] i_player_y = '0;
    logic [11:0] i_view_angle = '0;
    logic [6:0]  i_column = '0;
    logic        o_empty;
    logic        i_pop = 0;
    logic [5:0]  o_row;
    logic [3:0]  o_glyph;
    logic [7:0]  o_distance_steps;
    logic        o_last_row;

    column_board board = new();
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;

    raycast_column_renderer_core i_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_glyph_beat got;
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && i_pop && !o_empty) begin
            got.row = o_row;
            got.glyph = o_glyph;
            got.steps = o_distance_steps;
            got.last = o_last_row;
            board.check(got);
        end
        i_pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic wait_idle();
        i_push <= 1'b0;
        while (board.glyphs_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic load_map(logic [255:0] m, logic [4:0] dep);
        wait_idle();
        write_reg(CFG_MAP_A, m[63:0]);
        write_reg(CFG_MAP_B, m[127:64]);
        write_reg(CFG_MAP_C, m[191:128]);
        write_reg(CFG_MAP_D, m[255:192]);
        write_reg(CFG_DEPTH, 64'(dep));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_column(logic [11:0] px, logic [11:0] py, logic [11:0] va,
                               logic [6:0] col);
        i_push <= 1'b1;
        i_player_x <= px;
        i_player_y <= py;
        i_view_angle <= va;
        i_column <= col;
        do @(posedge i_clk); while (o_full);
        board.note_column(px, py, va, col);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
    endtask

    function automatic logic [255:0] room_map(int density);
        logic [255:0] m;
        for (int y = 0; y < 16; y++)
            for (int x = 0; x < 16; x++)
                m[y * 16 + x] = (x == 0 || y == 0 || x == 15 || y == 15) ||
                                ($urandom_range(0, 99) < density);
        return m;
    endfunction

    task automatic random_columns(int n);
        logic [11:0] px, py;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 8) begin
                px = 12'($urandom_range(256, 3839));
                py = 12'($urandom_range(256, 3839));
            end else begin
                px = 12'($urandom());
                py = 12'($urandom());
            end
            send_column(px, py, 12'($urandom()), 7'($urandom_range(0, 127)));
        end
    endtask

    initial begin
        logic [255:0] m;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, map edge, empty map, full map
        send_column(12'd0, 12'd0, 12'd0, 7'd0);
        send_column(12'd4095, 12'd4095, 12'd4095, 7'd119);
        send_column(12'd2048, 12'd2048, 12'd1024, 7'd127);
        send_column(12'd0, 12'd4095, 12'd2048, 7'd60);
        load_map(room_map(0), 5'd16);
        send_column(12'd2048, 12'd2048, 12'd0, 7'd0);
        send_column(12'd2048, 12'd2048, 12'd1024, 7'd60);
        send_column(12'd2048, 12'd2048, 12'd2048, 7'd119);
        send_column(12'd2048, 12'd2048, 12'd3072, 7'd127);
        send_column(12'd384, 12'd384, 12'd2560, 7'd60);
        send_column(12'd300, 12'd2048, 12'd3072, 7'd60);
        send_column(12'd3800, 12'd3800, 12'd512, 7'd60);
        send_column(12'd0, 12'd0, 12'd512, 7'd64);
        load_map({256{1'b1}}, 5'd0);
        send_column(12'd2048, 12'd2048, 12'd0, 7'd0);
        send_column(12'd4095, 12'd0, 12'd4095, 7'd127);
        load_map(room_map(0), 5'd31);
        send_column(12'd2048, 12'd2048, 12'd100, 7'd10);
        load_map(room_map(0), 5'd1);
        send_column(12'd2048, 12'd2048, 12'd100, 7'd10);
        send_column(12'd300, 12'd300, 12'd2560, 7'd60);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            idle_pct  = (ph % 4 == 1) ? 77 : (ph % 4 == 3) ? 21 : 0;
            stall_pct = (ph % 4 == 2) ? 77 : (ph % 4 == 3) ? 21 : 0;
            case (ph)
                0: m = room_map(10);
                1: m = room_map(30);
                2: m = '0;
                3: m = {$urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom(), $urandom()};
                4: m = room_map(5);
                5: m = room_map(50);
                6: m = room_map(15);
                default: m = room_map(2);
            endcase
            load_map(m, (ph == 6) ? 5'd3 : (ph == 7) ? 5'd8 : 5'd16);
            random_columns(38);
        end
        wait_idle();
        if (board.mismatches == 0 && board.glyphs_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
